/* rtl/lat_pkg.sv */
package lat_pkg;

  localparam int ROWS  = 64;
  localparam int COLS  = 64;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int CNT_W = $clog2(ROWS + 2);

  typedef logic [COLS-1:0] row_t;

endpackage

/* rtl/life_automaton_torus.sv */
// Cell commands (set, toggle, read, clear) and refused commands: done rises on leaving
// S_MODIFY and busy drops in that same cycle, so no new command is taken until the last is
// done. Step: rows are read one per cycle through the shared read address, plus two
// wrap-around rows to fill the row window; done comes once the last new row is written.
// Synchronous reset stops the automaton and marks every row invalid, so the grid reads dead
// at once with no clearing pass. The receiver cannot stall; done lasts one cycle.
module life_automaton_torus import lat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] cmd,
  input  logic [5:0] row_index,
  input  logic [5:0] col_index,
  input  logic       cell_in,
  output logic       done,
  output logic       cell_out,
  output logic       status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_ACCESS, S_MODIFY, S_SWEEP, S_DRAIN} state_t;
  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_TOGGLE = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  state_t            state;
  logic              running;
  logic              sel;
  logic [ROWS-1:0]   row_valid;
  cmd_t              cmd_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              val_q;
  logic              ok_q;
  logic [CNT_W-1:0]  cnt;
  logic              arr_valid;
  logic [CNT_W-1:0]  arr_k;
  logic              cmp_valid;
  logic [ROW_W-1:0]  cmp_row;
  logic              vmask;
  row_t              upper, mid, lower;
  row_t              rd_a, rd_b, row_eff, mod_row, next_row;
  logic [ROW_W-1:0]  rd_row, raddr;
  logic              mem_we, wbank, cmd_wr, bit_cur, in_ok;
  logic [ROW_W-1:0]  mem_waddr;
  row_t              mem_wdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_ok     = (32'(row_index) < ROWS) && (32'(col_index) < COLS);

  always_comb begin
    if (cnt == '0) begin
      rd_row = ROW_W'(ROWS - 1);
    end else if (cnt == CNT_W'(ROWS + 1)) begin
      rd_row = '0;
    end else begin
      rd_row = ROW_W'(cnt - CNT_W'(1));
    end
    raddr = (state == S_SWEEP) ? rd_row : (ok_q ? row_q : '0);
  end

  assign row_eff = vmask ? (sel ? rd_b : rd_a) : '0;
  assign bit_cur = row_eff[col_q];
  assign cmd_wr  = (state == S_MODIFY) && ok_q &&
                   ((cmd_q == CMD_SET) || ((cmd_q == CMD_TOGGLE) && !running));

  always_comb begin
    mod_row        = row_eff;
    mod_row[col_q] = (cmd_q == CMD_SET) ? val_q : ~bit_cur;
    mem_we         = cmd_wr;
    mem_waddr      = row_q;
    mem_wdata      = mod_row;
    wbank          = sel;
    if (cmp_valid) begin
      mem_we    = 1'b1;
      mem_waddr = cmp_row;
      mem_wdata = next_row;
      wbank     = ~sel;
    end
  end

  lat_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_bank_a (
    .clk   (clk),
    .we    (mem_we && !wbank),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rd_a)
  );

  lat_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_bank_b (
    .clk   (clk),
    .we    (mem_we && wbank),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (rd_b)
  );

  lat_row_rule u_rule (
    .upper    (upper),
    .mid      (mid),
    .lower    (lower),
    .next_row (next_row)
  );

  always_ff @(posedge clk) begin
    vmask <= row_valid[raddr];
    if (arr_valid) begin
      upper <= mid;
      mid   <= lower;
      lower <= row_eff;
    end
    arr_k   <= cnt;
    cmp_row <= ROW_W'(arr_k - CNT_W'(2));
    if (rst) begin
      arr_valid <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      arr_valid <= (state == S_SWEEP);
      cmp_valid <= arr_valid && (arr_k >= CNT_W'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      running   <= 1'b0;
      sel       <= 1'b0;
      row_valid <= '0;
      done      <= 1'b0;
      cell_out  <= 1'b0;
      status    <= 1'b0;
      cnt       <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        running <= cfg_data;
      end
      if (cmd_wr) begin
        row_valid[row_q] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd_t'(cmd);
            row_q <= ROW_W'(row_index);
            col_q <= COL_W'(col_index);
            val_q <= cell_in;
            ok_q  <= in_ok;
            state <= S_ACCESS;
          end
        end
        S_ACCESS: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          done     <= 1'b1;
          cell_out <= 1'b0;
          status   <= 1'b0;
          state    <= S_IDLE;
          case (cmd_q)
            CMD_SET: begin
              cell_out <= ok_q & val_q;
            end
            CMD_TOGGLE: begin
              status   <= running;
              cell_out <= ok_q & (running ? bit_cur : ~bit_cur);
            end
            CMD_CLEAR: begin
              status <= running;
              if (!running) begin
                row_valid <= '0;
              end
            end
            CMD_STEP: begin
              if (running) begin
                done  <= 1'b0;
                cnt   <= '0;
                state <= S_SWEEP;
              end else begin
                status <= 1'b1;
              end
            end
            CMD_READ: begin
              cell_out <= ok_q & bit_cur;
            end
            default: begin
            end
          endcase
        end
        S_SWEEP: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(ROWS + 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (cmp_valid && (cmp_row == ROW_W'(ROWS - 1))) begin
            sel       <= ~sel;
            row_valid <= '1;
            done      <= 1'b1;
            cell_out  <= 1'b0;
            status    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe raised while a command is still in progress.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("Accepted command did not hold the block busy.");

  a_sweep_bank: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (wbank != sel && (state == S_SWEEP || state == S_DRAIN)))
    else $error("Next generation row written outside a step or into the live grid.");

  a_cmd_bank: assert property (@(posedge clk) disable iff (rst)
    cmd_wr |-> (wbank == sel && !cmp_valid))
    else $error("Cell write did not target the live grid.");

endmodule

/* rtl/lat_ram.sv */
module lat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lat_row_rule.sv */
module lat_row_rule import lat_pkg::*; (
  input  row_t upper,
  input  row_t mid,
  input  row_t lower,
  output row_t next_row
);

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    localparam int L = (c == 0) ? COLS - 1 : c - 1;
    localparam int R = (c == COLS - 1) ? 0 : c + 1;
    logic [3:0] sum;

    assign sum = 4'(upper[L]) + 4'(upper[c]) + 4'(upper[R])
               + 4'(mid[L])   + 4'(mid[R])
               + 4'(lower[L]) + 4'(lower[c]) + 4'(lower[R]);
    assign next_row[c] = (sum == 4'd3) | (mid[c] & (sum == 4'd2));
  end

endmodule

/* tb/life_cmd_pkg.sv */
`timescale 1ns / 100ps
package life_cmd_pkg;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_TOGGLE = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_READ   = 3'd4
  } life_cmd_e;

  // Codes above CMD_READ up to this value are undefined commands.
  localparam logic [2:0] CMD_CODE_MAX = 3'd7;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

endpackage

/* tb/life_grid_checker.sv */
`timescale 1ns / 100ps
module life_grid_checker import lat_pkg::*, life_cmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] cmd,
  input  logic [5:0] row_index,
  input  logic [5:0] col_index,
  input  logic       cell_in,
  input  logic       done,
  input  logic       cell_out,
  input  logic       status,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic cell_val;
    logic status;
  } reply_t;

  reply_t predicted_replies[$];
  bit     board [ROWS][COLS];
  bit     running;

  function automatic void wipe_board();
    foreach (board[i, j]) board[i][j] = 1'b0;
  endfunction

  function automatic int live_neighbours(int r, int c);
    int total;
    total = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (dr != 0 || dc != 0)
          total += board[(r + ROWS + dr) % ROWS][(c + COLS + dc) % COLS];
    return total;
  endfunction

  // The whole next generation is worked out from the old board before it is replaced.
  function automatic void evolve_board();
    bit nxt [ROWS][COLS];
    int n;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        n = live_neighbours(r, c);
        nxt[r][c] = (n == 3) || (board[r][c] && n == 2);
      end
    end
    board = nxt;
  endfunction

  function automatic reply_t predict_reply(logic [2:0] code, int r, int c, logic v);
    reply_t rep;
    logic   on_board;
    rep      = '{cell_val: 1'b0, status: STATUS_DONE};
    on_board = (r < ROWS) && (c < COLS);
    case (code)
      CMD_SET: begin
        if (on_board) begin
          board[r][c]  = v;
          rep.cell_val = v;
        end
      end
      CMD_TOGGLE: begin
        if (running) rep.status = STATUS_REFUSED;
        else if (on_board) board[r][c] = !board[r][c];
        if (on_board) rep.cell_val = board[r][c];
      end
      CMD_CLEAR: begin
        if (running) rep.status = STATUS_REFUSED;
        else wipe_board();
      end
      CMD_STEP: begin
        if (running) evolve_board();
        else rep.status = STATUS_REFUSED;
      end
      CMD_READ: begin
        if (on_board) rep.cell_val = board[r][c];
      end
      default: ;
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      wipe_board();
      running = 1'b0;
      predicted_replies.delete();
    end else begin
      if (done) begin
        if (predicted_replies.size() == 0) begin
          $error("result with no command outstanding: cell_out %0d, status %0d",
                 cell_out, status);
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (cell_out !== want.cell_val) begin
            $error("cell_out: expected %0d, got %0d", want.cell_val, cell_out);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) running = cfg_data;
      if (start && !busy)
        predicted_replies.push_back(predict_reply(cmd, row_index, col_index, cell_in));
    end
    pending = predicted_replies.size();
  end

endmodule

/* tb/tb_life_automaton_torus.sv */
`timescale 1ns / 100ps
module tb_life_automaton_torus;
  import lat_pkg::*;
  import life_cmd_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  logic [2:0] cmd       = CMD_READ;
  logic [5:0] row_index = '0;
  logic [5:0] col_index = '0;
  logic       cell_in   = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_data  = 1'b0;
  logic       busy;
  logic       done;
  logic       cell_out;
  logic       status;
  logic       cfg_ready;
  int         fail_count;
  int         pending;

  int burst_left    = 0;
  int commands_sent = 0;
  int steps_sent    = 0;
  int reg_writes    = 0;

  always #1 clk = ~clk;

  life_automaton_torus dut (.*);

  life_grid_checker grid_check (.*);

  function automatic int wrap(int x, int n);
    return ((x % n) + n) % n;
  endfunction

  function automatic int near(int base, int n);
    return wrap(base + int'($urandom_range(0, 4)) - 2, n);
  endfunction

  // Bursts of back-to-back commands separated by idle gaps of random length.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic issue(logic [2:0] code, int r, int c, logic v);
    start     <= 1'b1;
    cmd       <= code;
    row_index <= r[5:0];
    col_index <= c[5:0];
    cell_in   <= v;
    do @(posedge clk); while (busy);
    commands_sent++;
    if (code == CMD_STEP) steps_sent++;
    pace();
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_running(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  // Plant a small pattern around a random spot, often on an edge so that it wraps,
  // then let it evolve for a few generations and look at it.
  task automatic seeded_run();
    int r0;
    int c0;
    write_running(1'b0);
    if ($urandom_range(0, 3) != 0)
      issue(CMD_CLEAR, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
            1'($urandom_range(0, 1)));
    r0 = $urandom_range(0, ROWS - 1);
    c0 = $urandom_range(0, COLS - 1);
    if ($urandom_range(0, 1)) r0 = $urandom_range(0, 1) ? 0 : ROWS - 1;
    if ($urandom_range(0, 1)) c0 = $urandom_range(0, 1) ? 0 : COLS - 1;
    repeat ($urandom_range(3, 8))
      issue(CMD_SET, near(r0, ROWS), near(c0, COLS), $urandom_range(0, 5) != 0);
    if ($urandom_range(0, 1))
      issue(CMD_TOGGLE, near(r0, ROWS), near(c0, COLS), 1'($urandom_range(0, 1)));
    write_running(1'b1);
    repeat ($urandom_range(1, 4)) begin
      issue(CMD_STEP, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
            1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2))
        issue(CMD_READ, near(r0, ROWS), near(c0, COLS), 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(1, 3))
      issue(CMD_READ, near(r0, ROWS), near(c0, COLS), 1'($urandom_range(0, 1)));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(3, 8))
      issue(3'($urandom_range(0, CMD_CODE_MAX)), $urandom_range(0, ROWS - 1),
            $urandom_range(0, COLS - 1), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) write_running(1'($urandom_range(0, 1)));
  endtask

  initial begin
    int directed_count;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_READ, 0, 0, 1'b0);
    issue(CMD_SET, ROWS - 1, 0, 1'b1);
    issue(CMD_SET, 0, 0, 1'b1);
    issue(CMD_SET, 1, 0, 1'b1);
    issue(CMD_TOGGLE, ROWS - 1, COLS - 1, 1'b1);
    issue(CMD_TOGGLE, ROWS - 1, COLS - 1, 1'b0);
    issue(CMD_STEP, 0, 0, 1'b0);
    issue(CMD_SET, ROWS - 1, COLS - 1, 1'b0);
    write_running(1'b1);
    issue(CMD_STEP, ROWS - 1, COLS - 1, 1'b1);
    issue(CMD_READ, 0, COLS - 1, 1'b0);
    issue(CMD_READ, 1, 0, 1'b1);
    issue(CMD_TOGGLE, 0, 0, 1'b0);
    issue(CMD_CLEAR, 0, 0, 1'b0);
    issue(CMD_SET, 5, 5, 1'b1);
    issue(CMD_SET, 5, 5, 1'b0);
    issue(CMD_CODE_MAX, ROWS - 1, COLS - 1, 1'b1);
    issue(CMD_STEP, 0, 0, 1'b0);
    write_running(1'b0);
    issue(CMD_READ, 0, 0, 1'b0);
    issue(CMD_CLEAR, ROWS - 1, COLS - 1, 1'b1);
    issue(CMD_READ, 0, 0, 1'b0);

    directed_count = commands_sent;
    while (commands_sent < directed_count + 120) begin
      if ($urandom_range(0, 3) != 0) seeded_run();
      else noise_burst();
      if ($urandom_range(0, 4) == 0) drain();
    end

    drain();
    repeat (ROWS + 16) @(posedge clk);
    $display("Ran %0d commands on the wrapped grid, %0d of them generation steps,",
             commands_sent, steps_sent);
    $display("with %0d writes of the running register between batches.", reg_writes);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
rtl/lat_pkg.sv
rtl/lat_ram.sv
rtl/lat_row_rule.sv
rtl/life_automaton_torus.sv
tb/life_cmd_pkg.sv
tb/life_grid_checker.sv
tb/tb_life_automaton_torus.sv
